// ===== rtl/msq_pkg.sv =====
// ----------------------------------------------------------------------------
// msq_pkg
// shared types, constants and the segment lookup for the marching squares cell
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

  localparam int GRID_DIM = 1024;

  localparam logic [2:0] REG_LEVEL    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
  localparam logic [2:0] REG_STEP_X   = 3'd3;
  localparam logic [2:0] REG_STEP_Y   = 3'd4;

  localparam logic [1:0] EDGE_B = 2'd0;
  localparam logic [1:0] EDGE_R = 2'd1;
  localparam logic [1:0] EDGE_T = 2'd2;
  localparam logic [1:0] EDGE_L = 2'd3;

  typedef struct packed {
    logic            none;
    logic            two;
    logic [3:0][1:0] e;
  } seg_t;

  typedef struct packed {
    logic            valid;
    logic            two;
    logic [3:0][1:0] e;
    logic [9:0]      col;
    logic [9:0]      row;
  } ctl_t;

  function automatic seg_t seg_lookup(input logic [3:0] cs, input logic up);
    seg_t r;
    r.none = 1'b0;
    r.two  = 1'b0;
    r.e    = '0;
    unique case (cs)
      4'd1, 4'd14: begin
        r.e[0] = EDGE_L; r.e[1] = EDGE_B;
      end
      4'd2, 4'd13: begin
        r.e[0] = EDGE_B; r.e[1] = EDGE_R;
      end
      4'd4, 4'd11: begin
        r.e[0] = EDGE_T; r.e[1] = EDGE_R;
      end
      4'd7, 4'd8: begin
        r.e[0] = EDGE_L; r.e[1] = EDGE_T;
      end
      4'd3, 4'd12: begin
        r.e[0] = EDGE_L; r.e[1] = EDGE_R;
      end
      4'd6, 4'd9: begin
        r.e[0] = EDGE_B; r.e[1] = EDGE_T;
      end
      4'd5, 4'd10: begin
        r.two = 1'b1;
        if ((cs == 4'd5) == up) begin
          r.e[0] = EDGE_L; r.e[1] = EDGE_T; r.e[2] = EDGE_B; r.e[3] = EDGE_R;
        end else begin
          r.e[0] = EDGE_L; r.e[1] = EDGE_B; r.e[2] = EDGE_T; r.e[3] = EDGE_R;
        end
      end
      default: begin
        r.none = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/msq_div.sv =====
// ----------------------------------------------------------------------------
// msq_div
// pipelined restoring divider, one quotient bit per stage, q = (na << F) / nd
// ----------------------------------------------------------------------------
`default_nettype none

module msq_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [15:0]          na,
  input  wire logic [16:0]          nd,
  output logic      [FRAC_BITS:0]   q
);

  localparam int QW = FRAC_BITS + 1;

  logic [16:0]   rem [QW];
  logic [16:0]   den [QW];
  logic [QW-1:0] quo [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [17:0]   trial;
    logic [17:0]   diff;
    logic          ge;
    logic [16:0]   den_in;
    logic [QW-1:0] quo_in;

    if (k == 0) begin : g_first
      assign trial  = {2'b00, na};
      assign den_in = nd;
      assign quo_in = '0;
    end else begin : g_rest
      assign trial  = {rem[k-1], 1'b0};
      assign den_in = den[k-1];
      assign quo_in = quo[k-1];
    end

    assign diff = trial - {1'b0, den_in};
    assign ge   = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[16:0] : trial[16:0];
        den[k] <= den_in;
        quo[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign q = (den[QW-1] == '0) ? '0 : quo[QW-1];

endmodule

`default_nettype wire

// ===== rtl/marching_squares_cell.sv =====
// ----------------------------------------------------------------------------
// marching_squares_cell
// marching squares isoline segments for one grid cell per transaction
// ----------------------------------------------------------------------------
// A cell transaction is taken on a clock edge with start high and busy low:
// four corner samples plus column and row. Each segment leaves on the result
// ports for one cycle with strobe high; last marks the final segment of the
// cell. Cells that give no segment (all corners on one side, or outside the
// grid) produce no strobe.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no cell is in flight.
// A cell passes the input, difference, magnitude, divider (one quotient bit
// per stage), multiply, base, edge point and output registers in turn.
// Throughput is one cell per cycle while busy is low. A saddle cell gives two
// segments on consecutive cycles; busy is high for one cycle and the whole
// pipeline holds.
// Reset clears the pipeline and loads level 0, origin 0 and step 1.0.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] sample_here,
  input  wire logic signed [15:0] sample_right,
  input  wire logic signed [15:0] sample_up_right,
  input  wire logic signed [15:0] sample_up,
  input  wire logic        [9:0]  cell_col,
  input  wire logic        [9:0]  cell_row,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [31:0] cfg_data,
  output logic                    strobe,
  output logic signed      [31:0] start_x,
  output logic signed      [31:0] start_y,
  output logic signed      [31:0] end_x,
  output logic signed      [31:0] end_y,
  output logic                    last
);

  localparam int QW = FRAC_BITS + 1;
  localparam int PW = 31 + QW;
  localparam logic [9:0] GRID_LAST = 10'(msq_pkg::GRID_DIM - 1);
  localparam logic GRID_FULL = (msq_pkg::GRID_DIM - 1) > 1023;

  logic signed [15:0] level;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [30:0] step_x;
  logic [30:0] step_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      origin_x <= '0;
      origin_y <= '0;
      step_x   <= 31'd65536;
      step_y   <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msq_pkg::REG_LEVEL:    level    <= cfg_data[15:0];
        msq_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        msq_pkg::REG_ORIGIN_Y: origin_y <= cfg_data;
        msq_pkg::REG_STEP_X:   step_x   <= cfg_data[30:0];
        msq_pkg::REG_STEP_Y:   step_y   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic stall;
  logic en;
  logic phase;

  assign en   = !stall;
  assign busy = stall;

  // stage 1: registered input
  logic                   s1_valid;
  logic [3:0][15:0]       s1_s;
  logic [9:0]             s1_col;
  logic [9:0]             s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s   <= {sample_up, sample_up_right, sample_right, sample_here};
      s1_col <= cell_col;
      s1_row <= cell_row;
    end
  end

  // stage 2: differences, case and segment selection
  logic [3:0][16:0] v;
  logic [3:0]       cs;
  logic [17:0]      sum;
  logic             up;
  logic             in_grid;
  msq_pkg::seg_t    seg;
  msq_pkg::ctl_t    s2_ctl;
  logic [3:0][16:0] s2_v;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      v[i]  = {s1_s[i][15], s1_s[i]} - {level[15], level};
      cs[i] = !v[i][16] && (v[i] != '0);
    end
    sum = {{2{s1_s[0][15]}}, s1_s[0]} + {{2{s1_s[1][15]}}, s1_s[1]}
        + {{2{s1_s[2][15]}}, s1_s[2]} + {{2{s1_s[3][15]}}, s1_s[3]};
    up      = $signed(sum) > $signed({level, 2'b00});
    in_grid = GRID_FULL || ((s1_col < GRID_LAST) && (s1_row < GRID_LAST));
    seg     = msq_pkg::seg_lookup(cs, up);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (en) begin
      s2_ctl.valid <= s1_valid && in_grid && !seg.none;
      s2_ctl.two   <= seg.two;
      s2_ctl.e     <= seg.e;
      s2_ctl.col   <= s1_col;
      s2_ctl.row   <= s1_row;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_v <= v;
    end
  end

  // stage 3: magnitudes per edge (bottom, right, top, left)
  logic [3:0][16:0] ea;
  logic [3:0][16:0] eb;
  logic [3:0][15:0] na;
  logic [3:0][16:0] nd;
  logic [3:0][17:0] d;
  logic [3:0][16:0] a_abs;
  msq_pkg::ctl_t    s3_ctl;

  always_comb begin
    ea[0] = s2_v[0]; eb[0] = s2_v[1];
    ea[1] = s2_v[1]; eb[1] = s2_v[2];
    ea[2] = s2_v[3]; eb[2] = s2_v[2];
    ea[3] = s2_v[0]; eb[3] = s2_v[3];
    for (int i = 0; i < 4; i++) begin
      d[i]     = {ea[i][16], ea[i]} - {eb[i][16], eb[i]};
      a_abs[i] = ea[i][16] ? 17'(-ea[i]) : ea[i];
    end
  end

  logic [3:0][15:0] s3_na;
  logic [3:0][16:0] s3_nd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else if (en) begin
      s3_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s3_na[i] <= a_abs[i][15:0];
        s3_nd[i] <= d[i][17] ? 17'(-d[i]) : d[i][16:0];
      end
    end
  end

  assign na = s3_na;
  assign nd = s3_nd;

  // divider stages
  logic [3:0][FRAC_BITS:0] q;
  msq_pkg::ctl_t           dl [QW];

  for (genvar i = 0; i < 4; i++) begin : g_div
    msq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .na  (na[i]),
      .nd  (nd[i]),
      .q   (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) begin
        dl[k] <= '0;
      end
    end else if (en) begin
      dl[0] <= s3_ctl;
      for (int k = 1; k < QW; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  // multiply stage
  msq_pkg::ctl_t    m_ctl;
  logic [3:0][31:0] m_off;
  logic [31:0]      m_colmul;
  logic [31:0]      m_rowmul;
  logic [3:0][PW-1:0] prod;
  logic [40:0]      colmul;
  logic [40:0]      rowmul;

  always_comb begin
    prod[0] = PW'(step_x) * PW'(q[0]);
    prod[1] = PW'(step_y) * PW'(q[1]);
    prod[2] = PW'(step_x) * PW'(q[2]);
    prod[3] = PW'(step_y) * PW'(q[3]);
    colmul  = 41'(dl[QW-1].col) * 41'(step_x);
    rowmul  = 41'(dl[QW-1].row) * 41'(step_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_ctl <= '0;
    end else if (en) begin
      m_ctl <= dl[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        m_off[i] <= prod[i][FRAC_BITS+31:FRAC_BITS];
      end
      m_colmul <= colmul[31:0];
      m_rowmul <= rowmul[31:0];
    end
  end

  // base stage
  msq_pkg::ctl_t    b_ctl;
  logic [3:0][31:0] b_off;
  logic [31:0]      b_x;
  logic [31:0]      b_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else if (en) begin
      b_ctl <= m_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_off <= m_off;
      b_x   <= origin_x + m_colmul;
      b_y   <= origin_y + m_rowmul;
    end
  end

  // edge point stage
  msq_pkg::ctl_t    p_ctl;
  logic [3:0][31:0] px;
  logic [3:0][31:0] py;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else if (en) begin
      p_ctl <= b_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px[msq_pkg::EDGE_B] <= b_x + b_off[0];
      py[msq_pkg::EDGE_B] <= b_y;
      px[msq_pkg::EDGE_R] <= b_x + {1'b0, step_x};
      py[msq_pkg::EDGE_R] <= b_y + b_off[1];
      px[msq_pkg::EDGE_T] <= b_x + b_off[2];
      py[msq_pkg::EDGE_T] <= b_y + {1'b0, step_y};
      px[msq_pkg::EDGE_L] <= b_x;
      py[msq_pkg::EDGE_L] <= b_y + b_off[3];
    end
  end

  // output stage, a saddle cell holds the pipeline for its second segment
  logic       second;
  logic [1:0] es;
  logic [1:0] ee;

  assign stall  = p_ctl.valid && p_ctl.two && !phase;
  assign second = p_ctl.two && phase;
  assign es     = second ? p_ctl.e[2] : p_ctl.e[0];
  assign ee     = second ? p_ctl.e[3] : p_ctl.e[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      phase  <= stall;
      strobe <= p_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    start_x <= px[es];
    start_y <= py[es];
    end_x   <= px[ee];
    end_y   <= py[ee];
    last    <= !p_ctl.two || phase;
  end

  a_pair_done : assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && last)
    else $error("first saddle segment not followed by the last one");

  a_busy_short : assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_first_from_hold : assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> $past(busy))
    else $error("non-final segment without a pipeline hold");

  a_hold_has_item : assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("hold cycle did not emit a segment");

endmodule

`default_nettype wire
